// ----- rtl/sawc_pkg.sv -----
// Shared types and fixed geometry for the set-associative write-back cache.
// No dependencies; imported by set_assoc_writeback_cache_unit.
package sawc_pkg;

  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned OFF_W      = 2;
  localparam int unsigned SET_W      = 3;
  localparam int unsigned LINE_BYTES = 1 << OFF_W;
  localparam int unsigned SETS       = 1 << SET_W;
  localparam int unsigned TAG_W      = ADDR_BITS - OFF_W - SET_W;
  localparam int unsigned LINE_W     = 8 * LINE_BYTES;
  localparam int unsigned ROW_W      = ADDR_BITS - OFF_W;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 command;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
    logic       dirty;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_ACCESS = 4'b1000
  } state_e;

endpackage

// ----- rtl/set_assoc_writeback_cache_unit.sv -----
// Set-associative write-back, write-allocate byte cache with LRU replacement
// and its own line-wide backing memory. Depends on sawc_pkg.
//
// Usage:
//   A beat on req_i is taken at a clock edge where start is high and busy is
//   low. A read produces one beat on rsp_o, marked by strobe_o for exactly one
//   cycle; a write produces none. The receiver cannot stall the result.
//   An access runs as steps: set metadata read at the accepting edge, line
//   and backing row read in the lookup step, write back of line, metadata
//   and victim in the access step. The read result is registered at the
//   edge that ends the access step, where busy drops too, so a new beat is
//   taken only once the last is done; one access is in flight at a time.
//   A miss moves whole lines, so a dirty eviction needs no extra step: the
//   backing memory is one port, one line wide.
//   Reset: the backing memory is zeroed by a clearing pass over all 2^14 =
//   16384 rows, one line per cycle, during which busy stays high. Cache sets
//   come out of reset invalid with LRU order 0..WAYS-1 via per-set init
//   flags, without a sweep.
module set_assoc_writeback_cache_unit
  import sawc_pkg::*;
#(
  parameter int unsigned WAYS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic strobe_o,
  output rsp_t rsp_o
);

  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned DIDX_W = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][WAY_W-1:0] order;
  } meta_t;

  state_e state_q, state_d;
  logic [ROW_W-1:0] clr_q, clr_d;
  logic [SETS-1:0] set_init_q;
  logic strobe_q, strobe_d;
  rsp_t rsp_q, rsp_d;
  req_t req_q;

  logic accept;
  logic [SET_W-1:0] set_i, set_q;
  logic [TAG_W-1:0] tag_q;
  logic [OFF_W-1:0] off_q;

  meta_t meta_mem [SETS];
  meta_t meta_rd_q;
  logic [LINE_W-1:0] data_mem [SETS*WAYS];
  logic [LINE_W-1:0] data_rd_q;
  logic [LINE_W-1:0] bk_mem [2**ROW_W];
  logic [LINE_W-1:0] bk_rd_q;

  meta_t meta_rst, meta_eff, meta_q, meta_new;
  logic hit_c, wb_c;
  logic [WAY_W-1:0] hit_way, victim, way_c;
  logic [ROW_W-1:0] wb_row_c;
  logic [DIDX_W-1:0] didx_c;
  logic hit_q, wb_q;
  logic [WAY_W-1:0] way_q;
  logic [ROW_W-1:0] wb_row_q;
  logic [DIDX_W-1:0] didx_q;

  logic [LINE_W-1:0] line_c;
  logic [7:0] byte_c;
  logic seen;

  logic bk_we;
  logic [ROW_W-1:0] bk_waddr;
  logic [LINE_W-1:0] bk_wdata;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign set_i  = req_i.address[OFF_W +: SET_W];
  assign set_q  = req_q.address[OFF_W +: SET_W];
  assign tag_q  = req_q.address[ADDR_BITS-1 -: TAG_W];
  assign off_q  = req_q.address[OFF_W-1:0];

  // lookup: hit search and victim choice
  always_comb begin
    meta_rst = '0;
    for (int k = 0; k < WAYS; k++) begin
      meta_rst.order[k] = WAY_W'(k);
    end
    meta_eff = set_init_q[set_q] ? meta_rd_q : meta_rst;
    hit_c    = 1'b0;
    hit_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && meta_eff.valid[w] && meta_eff.tag[w] == tag_q) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    victim = meta_eff.order[0];
    if ({1'b0, victim} >= (WAY_W + 1)'(WAYS)) begin
      victim = '0;
    end
    way_c    = hit_c ? hit_way : victim;
    wb_c     = !hit_c && meta_eff.valid[victim] && meta_eff.dirty[victim];
    wb_row_c = {meta_eff.tag[victim], set_q};
    didx_c   = DIDX_W'(int'(set_q) * int'(WAYS) + int'(way_c));
  end

  // access: line merge, metadata and LRU update
  always_comb begin
    line_c = hit_q ? data_rd_q : bk_rd_q;
    for (int b = 0; b < LINE_BYTES; b++) begin
      if (req_q.command == CMD_WRITE && OFF_W'(b) == off_q) begin
        line_c[8*b +: 8] = req_q.write_data;
      end
    end
    byte_c = line_c[8*off_q +: 8];

    meta_new             = meta_q;
    meta_new.tag[way_q]   = tag_q;
    meta_new.valid[way_q] = 1'b1;
    meta_new.dirty[way_q] = (req_q.command == CMD_WRITE) ||
                            (hit_q && meta_q.dirty[way_q]);
    seen = 1'b1;
    for (int k = 0; k < WAYS; k++) begin
      if (meta_q.order[k] == way_q) begin
        seen = 1'b0;
      end
    end
    for (int k = 0; k < WAYS - 1; k++) begin
      seen = seen || (meta_q.order[k] == way_q);
      if (seen) begin
        meta_new.order[k] = meta_q.order[k+1];
      end
    end
    meta_new.order[WAYS-1] = way_q;

    strobe_d = (state_q == S_ACCESS) && (req_q.command == CMD_READ);
    rsp_d    = '{read_data: byte_c, hit: hit_q, dirty: meta_new.dirty[way_q]};
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: state_d = S_ACCESS;
      S_ACCESS: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      set_init_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
      if (state_q == S_ACCESS) begin
        set_init_q[set_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_LOOKUP) begin
      hit_q    <= hit_c;
      wb_q     <= wb_c;
      way_q    <= way_c;
      wb_row_q <= wb_row_c;
      didx_q   <= didx_c;
      meta_q   <= meta_eff;
    end
    if (strobe_d) begin
      rsp_q <= rsp_d;
    end
  end

  // set metadata memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACCESS) begin
      meta_mem[set_q] <= meta_new;
    end
    if (accept) begin
      meta_rd_q <= meta_mem[set_i];
    end
  end

  // line data memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACCESS) begin
      data_mem[didx_q] <= line_c;
    end
    if (state_q == S_LOOKUP) begin
      data_rd_q <= data_mem[didx_c];
    end
  end

  // backing memory, single port
  assign bk_we    = (state_q == S_CLEAR) || ((state_q == S_ACCESS) && wb_q);
  assign bk_waddr = (state_q == S_CLEAR) ? clr_q : wb_row_q;
  assign bk_wdata = (state_q == S_CLEAR) ? '0 : data_rd_q;

  always_ff @(posedge clk_i) begin
    if (bk_we) begin
      bk_mem[bk_waddr] <= bk_wdata;
    end else if (state_q == S_LOOKUP) begin
      bk_rd_q <= bk_mem[req_q.address[ADDR_BITS-1:OFF_W]];
    end
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  a_accept_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOKUP) ##1 (state_q == S_ACCESS))
    else $error("accepted beat did not reach the access step");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q == S_ACCESS && req_q.command == CMD_READ))
    else $error("result strobe without a read access");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !rsp_o.hit |-> !rsp_o.dirty)
    else $error("read miss reported a dirty line");

  a_wb_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS) && wb_q |-> wb_row_q != req_q.address[ADDR_BITS-1:OFF_W])
    else $error("write-back targets the line being filled");

endmodule

// ----- dv/tb_set_assoc_writeback_cache_unit.sv -----
// Self-checking testbench for set_assoc_writeback_cache_unit: directed and random
// byte reads and writes, checked against a local LRU write-back cache model.
// Depends on sawc_pkg and the cache unit RTL.
module tb_set_assoc_writeback_cache_unit;
  import sawc_pkg::*;

  localparam int NWAYS          = 5;
  localparam int RANDOM_BEATS   = 430;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct {
    req_t        beat;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_q  = '0;
  logic busy;
  logic strobe_o;
  rsp_t rsp_o;

  stim_t stim_q[$];
  stim_t next_item;
  rsp_t  read_expect_q[$];
  bit    no_idle = 1'b0;
  int    idle_run = 0;
  int    open_reads = 0;
  int    quiet_cycles = 0;
  int    fail_cnt = 0;
  int    beats_taken = 0;
  int    reads_checked = 0;
  int    hit_cnt = 0;
  int    writeback_cnt = 0;

  // cache and backing memory image
  logic [7:0]       mem_image [65536];
  logic [7:0]       line_data [SETS][NWAYS][LINE_BYTES];
  logic [TAG_W-1:0] line_tag_m [SETS][NWAYS];
  bit               line_ok [SETS][NWAYS];
  bit               line_dirty_m [SETS][NWAYS];
  int               lru_order [SETS][NWAYS];

  set_assoc_writeback_cache_unit #(
    .WAYS(NWAYS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_q),
    .strobe_o(strobe_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic cache_access(input req_t b, output bit has_rsp, output rsp_t rsp);
    logic [OFF_W-1:0] off;
    logic [SET_W-1:0] set_ix;
    logic [TAG_W-1:0] tag;
    int               way;
    int               pos;
    bit               hit;
    off    = b.address[OFF_W-1:0];
    set_ix = b.address[OFF_W +: SET_W];
    tag    = b.address[ADDR_BITS-1 -: TAG_W];
    way    = 0;
    hit    = 1'b0;
    rsp    = '0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!hit && line_ok[set_ix][w] && line_tag_m[set_ix][w] == tag) begin
        way = w;
        hit = 1'b1;
      end
    end
    if (hit) begin
      hit_cnt++;
    end else begin
      way = lru_order[set_ix][0];
      if (line_ok[set_ix][way] && line_dirty_m[set_ix][way]) begin
        writeback_cnt++;
        for (int i = 0; i < LINE_BYTES; i++)
          mem_image[{line_tag_m[set_ix][way], set_ix, OFF_W'(i)}] = line_data[set_ix][way][i];
      end
      for (int i = 0; i < LINE_BYTES; i++)
        line_data[set_ix][way][i] = mem_image[{tag, set_ix, OFF_W'(i)}];
      line_tag_m[set_ix][way]   = tag;
      line_ok[set_ix][way]      = 1'b1;
      line_dirty_m[set_ix][way] = 1'b0;
    end
    // move the touched way to the most recent end
    pos = 0;
    for (int k = NWAYS - 1; k >= 0; k--)
      if (lru_order[set_ix][k] == way) pos = k;
    for (int k = pos; k < NWAYS - 1; k++)
      lru_order[set_ix][k] = lru_order[set_ix][k+1];
    lru_order[set_ix][NWAYS-1] = way;
    if (b.command == CMD_WRITE) begin
      line_data[set_ix][way][off] = b.write_data;
      line_dirty_m[set_ix][way]   = 1'b1;
      has_rsp = 1'b0;
    end else begin
      rsp.read_data = line_data[set_ix][way][off];
      rsp.hit       = hit;
      rsp.dirty     = line_dirty_m[set_ix][way];
      has_rsp = 1'b1;
    end
  endtask

  task automatic push_beat(input cmd_e c, input logic [15:0] a, input logic [7:0] d,
                           input bit drain);
    stim_t s;
    s.beat.command    = c;
    s.beat.address    = a;
    s.beat.write_data = d;
    s.gap             = no_idle ? 0 : $urandom_range(0, 3);
    s.drain           = drain;
    stim_q.push_back(s);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req_q    <= '0;
      idle_run <= 0;
    end else if (!start || !busy) begin
      if (stim_q.size() != 0 && idle_run >= stim_q[0].gap &&
          !(stim_q[0].drain && (start || busy || open_reads != 0))) begin
        next_item = stim_q.pop_front();
        start    <= 1'b1;
        req_q    <= next_item.beat;
        idle_run <= 0;
      end else begin
        start    <= 1'b0;
        idle_run <= idle_run + 1;
      end
    end
  end

  // monitor: checks result beats, then predicts from accepted request beats
  always @(posedge clk_i or negedge rst_ni) begin
    bit   has_rsp;
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      for (int a = 0; a < 65536; a++) mem_image[a] = 8'h00;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < NWAYS; w++) begin
          line_ok[s][w]      = 1'b0;
          line_dirty_m[s][w] = 1'b0;
          line_tag_m[s][w]   = '0;
          lru_order[s][w]    = w;
          for (int i = 0; i < LINE_BYTES; i++) line_data[s][w][i] = 8'h00;
        end
      end
      read_expect_q.delete();
      open_reads   <= 0;
      quiet_cycles <= 0;
    end else begin
      if (strobe_o) begin
        if (read_expect_q.size() == 0) begin
          $error("result beat with none expected: read_data %0h hit %0b dirty %0b",
                 rsp_o.read_data, rsp_o.hit, rsp_o.dirty);
          fail_cnt++;
        end else begin
          want = read_expect_q.pop_front();
          reads_checked++;
          if (rsp_o.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, rsp_o.read_data);
            fail_cnt++;
          end
          if (rsp_o.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, rsp_o.hit);
            fail_cnt++;
          end
          if (rsp_o.dirty !== want.dirty) begin
            $error("dirty: expected %0b, actual %0b", want.dirty, rsp_o.dirty);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        beats_taken++;
        cache_access(req_q, has_rsp, got);
        if (has_rsp) read_expect_q.push_back(got);
      end
      open_reads   <= read_expect_q.size();
      quiet_cycles <= (strobe_o || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat moved for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [TAG_W-1:0] tag_pool [6];
    logic [15:0]      a;

    // set 7, then set 0: fill all ways of set 0, three of them dirty, evict, read back through memory
    push_beat(CMD_READ,  16'h0000, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'hFFFF, 8'($urandom), 1'b0);
    push_beat(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b0);
    push_beat(CMD_READ,  16'hFFFF, 8'($urandom), 1'b0);
    push_beat(CMD_WRITE, 16'hFFFE, 8'h00, 1'b0);
    push_beat(CMD_READ,  16'hFFFE, 8'($urandom), 1'b0);
    push_beat(CMD_WRITE, 16'h0001, 8'h5A, 1'b0);
    push_beat(CMD_WRITE, 16'h0022, 8'hA5, 1'b0);
    push_beat(CMD_WRITE, 16'h0043, 8'h3C, 1'b0);
    push_beat(CMD_READ,  16'h0060, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'h0080, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'h00A0, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'h0001, 8'($urandom), 1'b1);
    push_beat(CMD_READ,  16'h0022, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'h0043, 8'($urandom), 1'b0);
    push_beat(CMD_READ,  16'h0001, 8'($urandom), 1'b0);
    push_beat(CMD_WRITE, 16'h0001, 8'hC3, 1'b0);
    push_beat(CMD_READ,  16'h0001, 8'($urandom), 1'b0);
    // set 3: clean victims only, with a re-touch to reorder
    for (int t = 0; t < 6; t++) begin
      push_beat(CMD_READ, 16'(t * 32 + 12), 8'($urandom), 1'b0);
      if (t == 2) push_beat(CMD_READ, 16'h000D, 8'($urandom), 1'b0);
    end

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int t = 2; t < 6; t++) tag_pool[t] = TAG_W'($urandom);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85)
        a = {tag_pool[$urandom_range(0, 5)], SET_W'($urandom), OFF_W'($urandom)};
      else
        a = 16'($urandom_range(0, 65535));
      push_beat(cmd_e'($urandom_range(0, 1)), a, 8'($urandom), $urandom_range(0, 63) == 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (stim_q.size() != 0 || start || open_reads != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (read_expect_q.size() != 0) begin
      $error("%0d read results never arrived", read_expect_q.size());
      fail_cnt++;
    end

    $display("Run: %0d beats accepted, %0d read results checked", beats_taken, reads_checked);
    $display("Cache: %0d hits, %0d misses, %0d dirty evictions written back",
             hit_cnt, beats_taken - hit_cnt, writeback_cnt);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sawc_pkg.sv
rtl/set_assoc_writeback_cache_unit.sv
dv/tb_set_assoc_writeback_cache_unit.sv
